>>> hw/rtl/vtcv_pkg.sv
// shared types, widths and helpers for the vertex transform, clip and viewport block
package vtcv_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CLIP_X_A  = 3'd0;
  localparam logic [2:0] REG_CLIP_X_B  = 3'd1;
  localparam logic [2:0] REG_CLIP_Y_A  = 3'd2;
  localparam logic [2:0] REG_CLIP_Y_B  = 3'd3;
  localparam logic [2:0] REG_CLIP_Z_A  = 3'd4;
  localparam logic [2:0] REG_CLIP_Z_B  = 3'd5;
  localparam logic [2:0] REG_VIEWPORT  = 3'd6;
  localparam logic [2:0] REG_WIN_H     = 3'd7;

  // exact row sum in Q.40: three 64-bit products plus the shifted offset
  localparam int SUM_W = 66;
  // clip value floored to Q.24
  localparam int C_W   = SUM_W - 16;
  // clamped clip value plus one, Q.24
  localparam int AX_W  = 44;
  // scaled axis value, Q.25
  localparam int MX_W  = 61;

  localparam logic signed [SUM_W-1:0] OUT_LIM  = SUM_W'(1) << 40;
  localparam logic signed [C_W-1:0]   CLIP_LIM = C_W'(1) << 42;
  localparam logic signed [C_W-1:0]   Q24_ONE  = C_W'(1) << 24;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } vtcv_row_ctl_t;

  // clamp a signed 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/vtcv_if.sv
// valid/ready channel interfaces for vertices in and pixels out
interface vtcv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface vtcv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;
  logic signed [31:0] depth;
  logic               outside_volume;

  modport source (output valid, output pixel_x, output pixel_y, output depth,
                  output outside_volume, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input depth,
                input outside_volume, output ready);
endinterface

>>> hw/rtl/vtcv_row.sv
// one matrix row: three registered products, then the registered exact sum
module vtcv_row
  import vtcv_pkg::*;
(
  input  logic                    clk,
  input  vtcv_row_ctl_t           ctl,
  input  logic signed [31:0]      vx,
  input  logic signed [31:0]      vy,
  input  logic signed [31:0]      vz,
  input  logic [63:0]             row_a,
  input  logic [63:0]             row_b,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [63:0] prod_x;
  logic signed [63:0] prod_y;
  logic signed [63:0] prod_z;
  logic signed [31:0] offset;
  logic signed [SUM_W-1:0] offset_w;

  assign offset   = $signed(row_b[63:32]);
  // offset is Q.24, lift to Q.40
  assign offset_w = {{(SUM_W-48){offset[31]}}, offset, 16'h0000};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_x <= vx * $signed(row_a[31:0]);
      prod_y <= vy * $signed(row_a[63:32]);
      prod_z <= vz * $signed(row_b[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum <= SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + offset_w;
    end
  end

endmodule

>>> hw/rtl/vertex_transform_clip_viewport.sv
// vertex transform, clip test and viewport map, six-stage pipeline
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  vertex   | in  | valid/ready        | coord_x, coord_y, coord_z (Q16.16)
//  pixel    | out | valid/ready        | pixel_x, pixel_y, depth (Q16.16), outside_volume
//  cfg      | in  | cfg_wr_en, no wait | cfg_index, cfg_data
//
// one vertex per cycle sustained while the pixel channel is ready
// stages: input register, nine 32x32 products, row sums, clip test and clamp,
// viewport scale multiply, origin add and saturation into the output register
// each stage holds while its successor is full and stalled, so bubbles close up
// synchronous reset clears the valid bits and all configuration registers to zero
module vertex_transform_clip_viewport
  import vtcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vtcv_in_if.sink     vertex,
  vtcv_out_if.source  pixel,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] clip_x_row_a;
  logic [63:0] clip_x_row_b;
  logic [63:0] clip_y_row_a;
  logic [63:0] clip_y_row_b;
  logic [63:0] clip_z_row_a;
  logic [63:0] clip_z_row_b;
  logic [63:0] viewport_box;
  logic [15:0] window_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_x_row_a  <= '0;
      clip_x_row_b  <= '0;
      clip_y_row_a  <= '0;
      clip_y_row_b  <= '0;
      clip_z_row_a  <= '0;
      clip_z_row_b  <= '0;
      viewport_box  <= '0;
      window_height <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLIP_X_A: clip_x_row_a  <= cfg_data;
        REG_CLIP_X_B: clip_x_row_b  <= cfg_data;
        REG_CLIP_Y_A: clip_y_row_a  <= cfg_data;
        REG_CLIP_Y_B: clip_y_row_b  <= cfg_data;
        REG_CLIP_Z_A: clip_z_row_a  <= cfg_data;
        REG_CLIP_Z_B: clip_z_row_b  <= cfg_data;
        REG_VIEWPORT: viewport_box  <= cfg_data;
        REG_WIN_H:    window_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [6:1] vld;
  logic [7:1] en;

  always_comb begin
    en[7] = pixel.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= vertex.valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign vertex.ready = en[1];

  // stage 1: input register
  logic signed [31:0] v_x;
  logic signed [31:0] v_y;
  logic signed [31:0] v_z;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v_x <= vertex.coord_x;
      v_y <= vertex.coord_y;
      v_z <= vertex.coord_z;
    end
  end

  // stages 2 and 3: products and exact row sums
  vtcv_row_ctl_t row_ctl;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;

  assign row_ctl.mul_en = en[2];
  assign row_ctl.sum_en = en[3];

  vtcv_row u_row_x (
    .clk (clk), .ctl (row_ctl), .vx (v_x), .vy (v_y), .vz (v_z),
    .row_a (clip_x_row_a), .row_b (clip_x_row_b), .sum (sum_x)
  );

  vtcv_row u_row_y (
    .clk (clk), .ctl (row_ctl), .vx (v_x), .vy (v_y), .vz (v_z),
    .row_a (clip_y_row_a), .row_b (clip_y_row_b), .sum (sum_y)
  );

  vtcv_row u_row_z (
    .clk (clk), .ctl (row_ctl), .vx (v_x), .vy (v_y), .vz (v_z),
    .row_a (clip_z_row_a), .row_b (clip_z_row_b), .sum (sum_z)
  );

  // stage 4: clip test, depth, clamp and bias of x and y
  logic signed [C_W-1:0]  c_x;
  logic signed [C_W-1:0]  c_y;
  logic signed [C_W-1:0]  cl_x;
  logic signed [C_W-1:0]  cl_y;
  logic signed [41:0]     dz;
  logic                   outside_next;
  logic signed [AX_W-1:0] ax_x;
  logic signed [AX_W-1:0] ax_y;
  logic signed [31:0]     depth4;
  logic                   outside4;

  always_comb begin
    c_x = $signed(sum_x[SUM_W-1:16]);
    c_y = $signed(sum_y[SUM_W-1:16]);
    cl_x = c_x;
    if (c_x > CLIP_LIM) cl_x = CLIP_LIM;
    if (c_x < -CLIP_LIM) cl_x = -CLIP_LIM;
    cl_y = c_y;
    if (c_y > CLIP_LIM) cl_y = CLIP_LIM;
    if (c_y < -CLIP_LIM) cl_y = -CLIP_LIM;
    dz = $signed(sum_z[SUM_W-1:24]);
    // exact compare against plus and minus one in Q.40
    outside_next = (sum_x > OUT_LIM) || (sum_x < -OUT_LIM) ||
                   (sum_y > OUT_LIM) || (sum_y < -OUT_LIM) ||
                   (sum_z > OUT_LIM) || (sum_z < -OUT_LIM);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ax_x     <= AX_W'(cl_x + Q24_ONE);
      ax_y     <= AX_W'(cl_y + Q24_ONE);
      depth4   <= sat32(64'(dz));
      outside4 <= outside_next;
    end
  end

  // stage 5: scale by viewport width and height
  logic signed [MX_W-1:0] mx_x;
  logic signed [MX_W-1:0] mx_y;
  logic signed [31:0]     depth5;
  logic                   outside5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mx_x     <= ax_x * $signed({1'b0, viewport_box[47:32]});
      mx_y     <= ax_y * $signed({1'b0, viewport_box[63:48]});
      depth5   <= depth4;
      outside5 <= outside4;
    end
  end

  // stage 6: add origin, flip y, floor to Q16.16 and saturate
  logic signed [15:0] org_x;
  logic signed [15:0] org_y;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [63:0] win_top;

  always_comb begin
    org_x   = $signed(viewport_box[15:0]);
    org_y   = $signed(viewport_box[31:16]);
    win_top = $signed({48'h0, window_height}) - 64'sd1;
    px = 64'(mx_x) + (64'(org_x) <<< 25);
    py = (win_top <<< 25) - (64'(org_y) <<< 25) - 64'(mx_y);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pixel.pixel_x        <= sat32(px >>> 9);
      pixel.pixel_y        <= sat32(py >>> 9);
      pixel.depth          <= depth5;
      pixel.outside_volume <= outside5;
    end
  end

  assign pixel.valid = vld[6];

  // an accepted vertex always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.ready) |=> vld[1])
    else $error("accepted vertex did not enter the pipeline");

  // a full pipeline behind a stalled output takes no vertex
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !pixel.ready) |-> !vertex.ready)
    else $error("vertex taken while pipeline full and stalled");

  // depth beyond plus or minus one must flag the vertex
  a_depth_clip: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && ((pixel.depth > 32'sh0001_0000) || (pixel.depth < -32'sh0001_0000)))
      |-> pixel.outside_volume)
    else $error("depth outside unit range without clip flag");

endmodule
